@@ hw/rtl/qsu_pkg.sv @@
// Types and constants shared by the quoted string unescaper.
package qsu_pkg;

	localparam int BYTE_W  = 8;
	localparam int KIND_W  = 2;
	localparam int ERR_W   = 2;
	localparam int CNT_W   = 13;
	localparam int PHASE_W = 3;
	localparam int OCTL_W  = 2;

	// Result queue geometry.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	// Scan phases.
	localparam logic [PHASE_W-1:0] PH_OUTSIDE = 3'd0;
	localparam logic [PHASE_W-1:0] PH_QUOTE   = 3'd1;
	localparam logic [PHASE_W-1:0] PH_BSLASH  = 3'd2;
	localparam logic [PHASE_W-1:0] PH_OCTAL   = 3'd3;
	localparam logic [PHASE_W-1:0] PH_DONE    = 3'd4;

	// Result kinds.
	localparam logic [KIND_W-1:0] KIND_BYTE   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FINISH = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd2;

	// Error codes.
	localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
	localparam logic [ERR_W-1:0] ERR_TRAILING = 2'd1;
	localparam logic [ERR_W-1:0] ERR_NOQUOTE  = 2'd2;
	localparam logic [ERR_W-1:0] ERR_UNTERM   = 2'd3;

	// Characters of interest.
	localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
	localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
	localparam logic [BYTE_W-1:0] CH_0      = 8'h30;
	localparam logic [BYTE_W-1:0] CH_3      = 8'h33;
	localparam logic [BYTE_W-1:0] CH_7      = 8'h37;
	localparam logic [BYTE_W-1:0] CH_N      = 8'h6E;
	localparam logic [BYTE_W-1:0] CH_R      = 8'h72;
	localparam logic [BYTE_W-1:0] CH_T      = 8'h74;
	localparam logic [BYTE_W-1:0] CODE_LF   = 8'h0A;
	localparam logic [BYTE_W-1:0] CODE_CR   = 8'h0D;
	localparam logic [BYTE_W-1:0] CODE_TAB  = 8'h09;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic [KIND_W-1:0] result_kind;
		logic [ERR_W-1:0]  error_code;
		logic [CNT_W-1:0]  consumed_count;
		logic              is_last;
	} result_t;

	function automatic result_t make_result(input logic [BYTE_W-1:0] b,
			input logic [KIND_W-1:0] kind, input logic [ERR_W-1:0] err,
			input logic [CNT_W-1:0] count);
		result_t r;
		r.out_byte       = b;
		r.result_kind    = kind;
		r.error_code     = err;
		r.consumed_count = count;
		r.is_last        = 1'b0;
		return r;
	endfunction

endpackage

@@ hw/rtl/quoted_string_unescaper.sv @@
// Quoted string unescaper: per-byte escape decoder with a small result queue.
//
// The block takes one raw byte per item on the input channel, plus an end item
// that closes the string, and delivers the unescaped bytes on the result
// channel. Inside double quotes it decodes backslash-n, -r and -t, octal
// escapes (up to three digits when the first is 0-3, two when it is 4-7) and a
// backslash before any other byte. The strict_mode register, written through
// the configuration channel (the user must write it only while the block is
// idle; the block does not enforce this), selects a single quoted string that
// must open with a quote and is finished by its closing quote; otherwise bytes
// outside quotes pass straight through. Each item is decoded in the cycle it is
// accepted and its zero, one or two results are written into a four-entry
// result queue, so an item can be accepted every cycle. Input ready is high
// while the queue holds two entries or fewer. The sustained rate is one item
// per cycle as long as items give at most one result each and the result
// channel is ready; it is bounded by the result port, which delivers one result
// per cycle, which holds back a run of octal flushes that give two results.
module quoted_string_unescaper #(
	parameter int MAX_STRING_LEN = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration channel
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        strict_mode,
	// input channel
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [qsu_pkg::BYTE_W-1:0]  data_byte,
	input  logic                        end_of_input,
	// result channel
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [qsu_pkg::BYTE_W-1:0]  out_byte,
	output logic [qsu_pkg::KIND_W-1:0]  result_kind,
	output logic [qsu_pkg::ERR_W-1:0]   error_code,
	output logic [qsu_pkg::CNT_W-1:0]   consumed_count,
	output logic                        is_last
);
	import qsu_pkg::*;

	// The byte position must be able to hold MAX_STRING_LEN itself.
	localparam int POS_W = $clog2(MAX_STRING_LEN + 1);

	// Stream state.
	logic              strict_q;
	logic [PHASE_W-1:0] phase_q;
	logic [BYTE_W-1:0] oct_q;
	logic [OCTL_W-1:0] left_q;
	logic [POS_W-1:0]  pos_q;
	logic [ERR_W-1:0]  err_q;

	// Result queue.
	result_t           queue_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	// Next-state and result logic.
	logic [PHASE_W-1:0] phase_d;
	logic [BYTE_W-1:0] oct_d;
	logic [OCTL_W-1:0] left_d;
	logic [POS_W-1:0]  pos_d;
	logic [ERR_W-1:0]  err_d;
	logic [POS_W-1:0]  pos_inc;
	logic [OCTL_W-1:0] left_dec;
	logic [BYTE_W-1:0] oct_shift;
	logic              is_digit;
	logic [1:0]        nres;
	result_t           res0;
	result_t           res1;

	// What a byte inside the quotes does, shared by the quote phase and by
	// the byte that flushes a short octal escape.
	logic [PHASE_W-1:0] qb_phase;
	logic              qb_emit;
	result_t           qb_res;

	logic in_acc;
	logic out_acc;

	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid && out_ready;
	assign in_ready  = (count_q <= QCNT_W'(QDEPTH - 2));
	assign out_valid = (count_q != '0);

	assign is_digit  = (data_byte >= CH_0) && (data_byte <= CH_7);
	assign pos_inc   = (pos_q < POS_W'(MAX_STRING_LEN)) ? pos_q + POS_W'(1) : pos_q;
	assign left_dec  = left_q - OCTL_W'(1);
	assign oct_shift = {oct_q[BYTE_W-4:0], data_byte[2:0]};

	always_comb begin
		qb_phase = PH_QUOTE;
		qb_emit  = 1'b0;
		qb_res   = make_result(data_byte, KIND_BYTE, ERR_NONE, '0);
		if (data_byte == CH_BSLASH) begin
			qb_phase = PH_BSLASH;
		end else if (data_byte == CH_QUOTE) begin
			if (strict_q) begin
				// Closing quote finishes the string with the count so far.
				qb_phase = PH_DONE;
				qb_emit  = 1'b1;
				qb_res   = make_result('0, KIND_FINISH, ERR_NONE, CNT_W'(pos_inc));
			end else begin
				qb_phase = PH_OUTSIDE;
			end
		end else begin
			qb_emit = 1'b1;
		end
	end

	always_comb begin
		phase_d = phase_q;
		oct_d   = oct_q;
		left_d  = left_q;
		pos_d   = pos_q;
		err_d   = err_q;
		nres    = 2'd0;
		res0    = make_result('0, KIND_BYTE, ERR_NONE, '0);
		res1    = make_result('0, KIND_BYTE, ERR_NONE, '0);

		if (end_of_input) begin
			if (err_q == ERR_NONE && phase_q != PH_DONE) begin
				nres = 2'd1;
				if (phase_q == PH_BSLASH) begin
					res0 = make_result('0, KIND_ERROR, ERR_TRAILING, '0);
				end else if (phase_q == PH_QUOTE || phase_q == PH_OCTAL) begin
					res0 = make_result('0, KIND_ERROR, ERR_UNTERM, '0);
				end else begin
					res0 = make_result('0, KIND_FINISH, ERR_NONE, '0);
				end
			end
			// Every end item starts a fresh stream.
			phase_d = PH_OUTSIDE;
			oct_d   = '0;
			left_d  = '0;
			pos_d   = '0;
			err_d   = ERR_NONE;
		end else if (err_q == ERR_NONE && phase_q != PH_DONE) begin
			pos_d = pos_inc;
			unique case (phase_q)
				PH_OUTSIDE: begin
					if (data_byte == CH_QUOTE) begin
						phase_d = PH_QUOTE;
					end else if (strict_q) begin
						err_d = ERR_NOQUOTE;
						nres  = 2'd1;
						res0  = make_result('0, KIND_ERROR, ERR_NOQUOTE, '0);
					end else begin
						nres = 2'd1;
						res0 = make_result(data_byte, KIND_BYTE, ERR_NONE, '0);
					end
				end
				PH_BSLASH: begin
					phase_d = PH_QUOTE;
					nres    = 2'd1;
					if (data_byte == CH_N) begin
						res0 = make_result(CODE_LF, KIND_BYTE, ERR_NONE, '0);
					end else if (data_byte == CH_R) begin
						res0 = make_result(CODE_CR, KIND_BYTE, ERR_NONE, '0);
					end else if (data_byte == CH_T) begin
						res0 = make_result(CODE_TAB, KIND_BYTE, ERR_NONE, '0);
					end else if (is_digit) begin
						nres    = 2'd0;
						oct_d   = {5'b0, data_byte[2:0]};
						left_d  = (data_byte > CH_3) ? OCTL_W'(1) : OCTL_W'(2);
						phase_d = PH_OCTAL;
					end else begin
						res0 = make_result(data_byte, KIND_BYTE, ERR_NONE, '0);
					end
				end
				PH_OCTAL: begin
					if (is_digit) begin
						oct_d  = oct_shift;
						left_d = left_dec;
						if (left_dec == '0) begin
							nres    = 2'd1;
							res0    = make_result(oct_shift, KIND_BYTE, ERR_NONE, '0);
							oct_d   = '0;
							phase_d = PH_QUOTE;
						end
					end else begin
						// Short escape: emit the value, then treat the byte
						// as an ordinary byte inside the quotes.
						nres    = 2'd1;
						res0    = make_result(oct_q, KIND_BYTE, ERR_NONE, '0);
						oct_d   = '0;
						left_d  = '0;
						phase_d = qb_phase;
						if (qb_emit) begin
							nres = 2'd2;
							res1 = qb_res;
						end
					end
				end
				default: begin
					phase_d = qb_phase;
					if (qb_emit) begin
						nres = 2'd1;
						res0 = qb_res;
					end
				end
			endcase
		end
		res0.is_last = (nres == 2'd1);
		res1.is_last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strict_q <= 1'b0;
			phase_q  <= PH_OUTSIDE;
			oct_q    <= '0;
			left_q   <= '0;
			pos_q    <= '0;
			err_q    <= ERR_NONE;
		end else begin
			if (cfg_valid && cfg_ready) begin
				strict_q <= strict_mode;
			end
			if (in_acc) begin
				phase_q <= phase_d;
				oct_q   <= oct_d;
				left_q  <= left_d;
				pos_q   <= pos_d;
				err_q   <= err_d;
			end
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (in_acc) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(nres);
			end
			if (out_acc) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + (in_acc ? QCNT_W'(nres) : '0)
				- (out_acc ? QCNT_W'(1) : '0);
		end
	end

	// Queue storage holds payload only.
	always_ff @(posedge clk) begin
		if (in_acc && nres != 2'd0) begin
			queue_q[wr_ptr_q] <= res0;
		end
		if (in_acc && nres == 2'd2) begin
			queue_q[wr_ptr_q + QPTR_W'(1)] <= res1;
		end
	end

	assign out_byte       = queue_q[rd_ptr_q].out_byte;
	assign result_kind    = queue_q[rd_ptr_q].result_kind;
	assign error_code     = queue_q[rd_ptr_q].error_code;
	assign consumed_count = queue_q[rd_ptr_q].consumed_count;
	assign is_last        = queue_q[rd_ptr_q].is_last;

endmodule
